// ===== hdl/wavhc_pkg.sv =====
package wavhc_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned WordW     = 32;
  localparam int unsigned HdrPosW   = 6;
  localparam int unsigned CfgIndexW = 2;

  localparam logic [HdrPosW-1:0] HdrLastPos  = 6'd43;
  localparam logic [HdrPosW-1:0] HdrSizePos  = 6'd40;

  localparam logic [WordW-1:0] SampleRateReset = 32'd22050;
  localparam logic [WordW-1:0] ByteRateReset   = 32'd44100;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_SAMPLE_RATE = 2'd0,
    CFG_BYTE_RATE   = 2'd1
  } cfg_index_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_RIFF_TAG   = 3'd1,
    ST_WAVE_TAG   = 3'd2,
    ST_FMT_TAG    = 3'd3,
    ST_FORMAT     = 3'd4,
    ST_DATA_TAG   = 3'd5,
    ST_SHORT_HDR  = 3'd6,
    ST_SHORT_DATA = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_DATA   = 3'b010,
    PH_DRAIN  = 3'b100
  } phase_e;

  typedef struct packed {
    logic [WordW-1:0] sample_rate;
    logic [WordW-1:0] byte_rate;
  } cfg_t;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               sample_valid;
    logic               done_res;
    status_e            status;
  } res_t;

  // Fixed header bytes; zero where a register decides or nothing is checked.
  function automatic logic [ByteW-1:0] hdr_expect(input logic [HdrPosW-1:0] pos);
    logic [ByteW-1:0] e;
    case (pos)
      6'd0:    e = 8'h52;
      6'd1:    e = 8'h49;
      6'd2:    e = 8'h46;
      6'd3:    e = 8'h46;
      6'd8:    e = 8'h57;
      6'd9:    e = 8'h41;
      6'd10:   e = 8'h56;
      6'd11:   e = 8'h45;
      6'd12:   e = 8'h66;
      6'd13:   e = 8'h6d;
      6'd14:   e = 8'h74;
      6'd15:   e = 8'h20;
      6'd16:   e = 8'd16;
      6'd20:   e = 8'd1;
      6'd22:   e = 8'd1;
      6'd32:   e = 8'd2;
      6'd34:   e = 8'd16;
      6'd36:   e = 8'h64;
      6'd37:   e = 8'h61;
      6'd38:   e = 8'h74;
      6'd39:   e = 8'h61;
      default: e = 8'h00;
    endcase
    return e;
  endfunction

  // Error code for a mismatch; ST_OK where the byte is not checked.
  function automatic status_e hdr_code(input logic [HdrPosW-1:0] pos);
    status_e c;
    case (pos) inside
      [6'd0:6'd3]:   c = ST_RIFF_TAG;
      [6'd8:6'd11]:  c = ST_WAVE_TAG;
      [6'd12:6'd15]: c = ST_FMT_TAG;
      [6'd16:6'd35]: c = ST_FORMAT;
      [6'd36:6'd39]: c = ST_DATA_TAG;
      default:       c = ST_OK;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/wav_header_check_sample_unpack_unit.sv =====
// Parses a canonical 44-byte PCM16 mono RIFF/WAVE header from a byte stream
// and unpacks the data chunk into signed little-endian 16-bit samples. One
// byte is taken per cycle while the queue has room. Each byte is handled in
// the cycle it is accepted and its result, if any, lands in a two-entry
// output queue, so input stalls only when both entries are occupied. A
// result carries a sample, an end-of-parse mark (tlast) with a final status,
// or both. After an error or the end of the declared data, bytes are dropped
// until the byte marked tlast; the next byte starts a new file. The expected
// sample rate (index 0) and byte rate (index 1) go through the config port;
// the user must write them only while the stream is idle (not enforced).
module wav_header_check_sample_unpack_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wavhc_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [wavhc_pkg::WordW-1:0]       cfg_data_i,
  // byte stream in
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [7:0]                        s_axis_tdata_i,  // [7:0] byte_value
  input  logic                              s_axis_tlast_i,  // last_byte
  // result stream out
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [15:0] sample, [16] sample_valid, [19:17] status, [23:20] zero
  output logic [23:0]                       m_axis_tdata_o,
  output logic                              m_axis_tlast_o   // done_res
);

  wavhc_pkg::cfg_t cfg;
  wavhc_pkg::res_t res;
  wavhc_pkg::res_t out_res;
  logic            res_push;
  logic            in_fire;

  assign in_fire = s_axis_tvalid_i & s_axis_tready_o;

  wavhc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  wavhc_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_fire_i  (in_fire),
    .byte_i     (s_axis_tdata_i),
    .last_i     (s_axis_tlast_i),
    .res_push_o (res_push),
    .res_o      (res)
  );

  wavhc_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res),
    .ready_o     (s_axis_tready_o),
    .valid_o     (m_axis_tvalid_o),
    .pop_ready_i (m_axis_tready_i),
    .data_o      (out_res)
  );

  assign m_axis_tdata_o = {4'b0000, out_res.status, out_res.sample_valid, out_res.sample};
  assign m_axis_tlast_o = out_res.done_res;

endmodule

// ===== hdl/wavhc_cfg.sv =====
module wavhc_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wavhc_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [wavhc_pkg::WordW-1:0]         cfg_data_i,
  output wavhc_pkg::cfg_t                     cfg_o
);

  logic [wavhc_pkg::WordW-1:0] sample_rate_q, sample_rate_d;
  logic [wavhc_pkg::WordW-1:0] byte_rate_q, byte_rate_d;
  logic                        wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  always_comb begin
    sample_rate_d = sample_rate_q;
    byte_rate_d   = byte_rate_q;
    if (wr_en) begin
      case (cfg_index_i)
        wavhc_pkg::CFG_SAMPLE_RATE: sample_rate_d = cfg_data_i;
        wavhc_pkg::CFG_BYTE_RATE:   byte_rate_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q <= wavhc_pkg::SampleRateReset;
      byte_rate_q   <= wavhc_pkg::ByteRateReset;
    end else begin
      sample_rate_q <= sample_rate_d;
      byte_rate_q   <= byte_rate_d;
    end
  end

  assign cfg_o.sample_rate = sample_rate_q;
  assign cfg_o.byte_rate   = byte_rate_q;

endmodule

// ===== hdl/wavhc_parse.sv =====
module wavhc_parse (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wavhc_pkg::cfg_t               cfg_i,
  input  logic                          in_fire_i,
  input  logic [wavhc_pkg::ByteW-1:0]   byte_i,
  input  logic                          last_i,
  output logic                          res_push_o,
  output wavhc_pkg::res_t               res_o
);

  wavhc_pkg::phase_e                   phase_q, phase_d;
  logic [wavhc_pkg::HdrPosW-1:0]       hdr_pos_q, hdr_pos_d;
  logic [wavhc_pkg::WordW-1:0]         field_q, field_d;
  logic [wavhc_pkg::WordW-1:0]         decl_q, decl_d;
  logic [wavhc_pkg::WordW-1:0]         seen_q, seen_d;
  logic [wavhc_pkg::ByteW-1:0]         hold_q, hold_d;

  logic [wavhc_pkg::HdrPosW-1:0]       pos;
  wavhc_pkg::status_e                  code;
  logic [wavhc_pkg::ByteW-1:0]         exp_byte;
  logic [wavhc_pkg::WordW-1:0]         field_new;
  logic [wavhc_pkg::WordW-1:0]         seen_inc;
  logic                                done;
  logic                                valid;
  logic [wavhc_pkg::SampleW-1:0]       smp;
  wavhc_pkg::status_e                  status;

  assign pos  = (hdr_pos_q > wavhc_pkg::HdrLastPos) ? wavhc_pkg::HdrLastPos : hdr_pos_q;
  assign code = wavhc_pkg::hdr_code(pos);

  // Rate fields come from the config words, low byte first.
  always_comb begin
    if (pos >= 6'd24 && pos <= 6'd27) begin
      exp_byte = cfg_i.sample_rate[{pos[1:0], 3'b000} +: wavhc_pkg::ByteW];
    end else if (pos >= 6'd28 && pos <= 6'd31) begin
      exp_byte = cfg_i.byte_rate[{pos[1:0], 3'b000} +: wavhc_pkg::ByteW];
    end else begin
      exp_byte = wavhc_pkg::hdr_expect(pos);
    end
  end

  assign field_new = field_q |
    (wavhc_pkg::WordW'(byte_i) << {pos[1:0], 3'b000});
  assign seen_inc  = seen_q + 32'd1;

  always_comb begin
    phase_d   = phase_q;
    hdr_pos_d = hdr_pos_q;
    field_d   = field_q;
    decl_d    = decl_q;
    seen_d    = seen_q;
    hold_d    = hold_q;
    done      = 1'b0;
    valid     = 1'b0;
    smp       = '0;
    status    = wavhc_pkg::ST_OK;
    if (in_fire_i) begin
      case (phase_q)
        wavhc_pkg::PH_HEADER: begin
          if (code != wavhc_pkg::ST_OK && byte_i != exp_byte) begin
            done   = 1'b1;
            status = code;
          end else begin
            if (pos >= wavhc_pkg::HdrSizePos) begin
              field_d = field_new;
            end
            if (pos == wavhc_pkg::HdrLastPos) begin
              decl_d = field_new;
              seen_d = '0;
              if (field_new == '0) begin
                done = 1'b1;
              end else begin
                phase_d = wavhc_pkg::PH_DATA;
                if (last_i) begin
                  done   = 1'b1;
                  status = wavhc_pkg::ST_SHORT_DATA;
                end
              end
            end else begin
              hdr_pos_d = pos + 6'd1;
              if (last_i) begin
                done   = 1'b1;
                status = wavhc_pkg::ST_SHORT_HDR;
              end
            end
          end
        end
        wavhc_pkg::PH_DATA: begin
          seen_d = seen_inc;
          if (seen_inc[0]) begin
            hold_d = byte_i;
          end else begin
            valid = 1'b1;
            smp   = {byte_i, hold_q};
          end
          if (seen_inc == decl_q) begin
            done = 1'b1;
          end else if (last_i) begin
            done   = 1'b1;
            status = wavhc_pkg::ST_SHORT_DATA;
          end
        end
        wavhc_pkg::PH_DRAIN: ;
        default: ;
      endcase
      // last byte starts a new file whatever happened above
      if (last_i) begin
        phase_d   = wavhc_pkg::PH_HEADER;
        hdr_pos_d = '0;
        field_d   = '0;
        decl_d    = '0;
        seen_d    = '0;
        hold_d    = '0;
      end else if (done) begin
        phase_d = wavhc_pkg::PH_DRAIN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= wavhc_pkg::PH_HEADER;
      hdr_pos_q <= '0;
      field_q   <= '0;
      decl_q    <= '0;
      seen_q    <= '0;
      hold_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      hdr_pos_q <= hdr_pos_d;
      field_q   <= field_d;
      decl_q    <= decl_d;
      seen_q    <= seen_d;
      hold_q    <= hold_d;
    end
  end

  assign res_push_o         = in_fire_i & (valid | done);
  assign res_o.sample       = smp;
  assign res_o.sample_valid = valid;
  assign res_o.done_res     = done;
  assign res_o.status       = status;

`ifndef ASSERT_OFF
  a_hdr_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_pos_q <= wavhc_pkg::HdrLastPos)
    else $error("header position past end of header");

  a_data_below_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == wavhc_pkg::PH_DATA |-> (seen_q < decl_q))
    else $error("data phase with declared size already consumed");

  a_sample_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.sample_valid) |-> phase_q == wavhc_pkg::PH_DATA)
    else $error("sample produced outside data phase");

  a_status_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && !res_o.done_res) |-> res_o.status == wavhc_pkg::ST_OK)
    else $error("status set without end of parse");
`endif

endmodule

// ===== hdl/wavhc_outq.sv =====
module wavhc_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wavhc_pkg::res_t push_data_i,
  output logic            ready_o,
  output logic            valid_o,
  input  logic            pop_ready_i,
  output wavhc_pkg::res_t data_o
);

  // Two entries: parser keeps running while one result waits downstream.
  wavhc_pkg::res_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            pop;
  logic            push;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign push    = push_i & ready_o;
  assign pop     = valid_o & pop_ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;

  localparam int NoFault = -1;
  localparam logic [31:0] RstSr = wavhc_pkg::SampleRateReset;
  localparam logic [31:0] RstBr = wavhc_pkg::ByteRateReset;
  localparam logic [31:0] TagRiff = "RIFF";
  localparam logic [31:0] TagWave = "WAVE";
  localparam logic [31:0] TagFmt  = "fmt ";
  localparam logic [31:0] TagData = "data";
  // data bytes 00 80, FF 7F, 00 00, FF FF: min, max, zero and minus one
  localparam logic [63:0] ExtremeData = 64'hFFFF_0000_7FFF_8000;

  typedef struct packed {
    logic [31:0]        sr;
    logic [31:0]        br;
    int                 fault_pos;
    int                 hdr_len;
    logic [31:0]        decl_size;
    int                 data_len;
    logic               pat;
    wavhc_pkg::status_e st;
  } dir_row_t;

  // a mismatch row stops one byte past the bad byte, so that byte is dropped
  localparam dir_row_t DirRows [20] = '{
    '{RstSr, RstBr, NoFault, 44, 32'd8, 8, 1'b1, wavhc_pkg::ST_OK},
    '{RstSr, RstBr, 0, 2, 32'd0, 0, 1'b0, wavhc_pkg::ST_RIFF_TAG},
    '{RstSr, RstBr, 8, 10, 32'd0, 0, 1'b0, wavhc_pkg::ST_WAVE_TAG},
    // mismatch inside a header that is also cut short
    '{RstSr, RstBr, 11, 20, 32'd2, 0, 1'b0, wavhc_pkg::ST_WAVE_TAG},
    '{RstSr, RstBr, 12, 14, 32'd0, 0, 1'b0, wavhc_pkg::ST_FMT_TAG},
    '{RstSr, RstBr, 16, 18, 32'd0, 0, 1'b0, wavhc_pkg::ST_FORMAT},
    '{RstSr, RstBr, 25, 27, 32'd0, 0, 1'b0, wavhc_pkg::ST_FORMAT},
    '{RstSr, RstBr, 33, 35, 32'd0, 0, 1'b0, wavhc_pkg::ST_FORMAT},
    '{RstSr, RstBr, 36, 38, 32'd0, 0, 1'b0, wavhc_pkg::ST_DATA_TAG},
    '{RstSr, RstBr, NoFault, 1, 32'd0, 0, 1'b0, wavhc_pkg::ST_SHORT_HDR},
    '{RstSr, RstBr, NoFault, 43, 32'd0, 0, 1'b0, wavhc_pkg::ST_SHORT_HDR},
    // mismatching byte is the one marked last
    '{RstSr, RstBr, 9, 10, 32'd0, 0, 1'b0, wavhc_pkg::ST_WAVE_TAG},
    '{RstSr, RstBr, NoFault, 44, 32'd0, 0, 1'b0, wavhc_pkg::ST_OK},
    '{RstSr, RstBr, NoFault, 44, 32'd6, 0, 1'b0, wavhc_pkg::ST_SHORT_DATA},
    '{RstSr, RstBr, NoFault, 44, 32'd8, 4, 1'b1, wavhc_pkg::ST_SHORT_DATA},
    '{RstSr, RstBr, NoFault, 44, 32'd5, 9, 1'b0, wavhc_pkg::ST_OK},
    '{32'd0, 32'hFFFF_FFFF, NoFault, 44, 32'd2, 2, 1'b1, wavhc_pkg::ST_OK},
    '{32'd0, 32'hFFFF_FFFF, 27, 29, 32'd0, 0, 1'b0, wavhc_pkg::ST_FORMAT},
    '{32'hFFFF_FFFF, 32'd0, 28, 30, 32'd0, 0, 1'b0, wavhc_pkg::ST_FORMAT},
    '{32'hFFFF_FFFF, 32'd0, NoFault, 44, 32'd4, 4, 1'b1, wavhc_pkg::ST_OK}
  };

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [wavhc_pkg::CfgIndexW-1:0] cfg_index_i = '0;
  logic [wavhc_pkg::WordW-1:0]     cfg_data_i = '0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [7:0]                      s_axis_tdata_i = '0;
  logic                            s_axis_tlast_i = 1'b0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [23:0]                     m_axis_tdata_o;
  logic                            m_axis_tlast_o;

  wav_header_check_sample_unpack_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // parser model state and its copy of the registers
  logic [wavhc_pkg::WordW-1:0]   want_sr = RstSr;
  logic [wavhc_pkg::WordW-1:0]   want_br = RstBr;
  wavhc_pkg::phase_e             ph = wavhc_pkg::PH_HEADER;
  logic [wavhc_pkg::HdrPosW-1:0] hpos = '0;
  logic [31:0]                   size_acc = '0;
  logic [31:0]                   data_size = '0;
  logic [31:0]                   data_cnt = '0;
  logic [7:0]                    low_hold = '0;

  wavhc_pkg::res_t results_due[$];
  int   mismatches = 0;
  int   sent_items = 0;
  logic idle_on = 1'b0;
  int   ready_hold = 0;

  // Byte a well-formed header holds at pos; chunk size is random.
  function automatic logic [7:0] hdr_good_byte(input int pos, input logic [31:0] sz);
    logic [159:0] fmt_body;
    logic [7:0]   v;
    fmt_body = {16'd16, 16'd2, want_br, want_sr, 16'd1, 16'd1, 32'd16};
    if (pos < 4) v = TagRiff[8*(3-pos) +: 8];
    else if (pos < 8) v = 8'($urandom);
    else if (pos < 12) v = TagWave[8*(11-pos) +: 8];
    else if (pos < 16) v = TagFmt[8*(15-pos) +: 8];
    else if (pos < 36) v = fmt_body[8*(pos-16) +: 8];
    else if (pos < 40) v = TagData[8*(39-pos) +: 8];
    else v = sz[8*(pos-40) +: 8];
    return v;
  endfunction

  function automatic wavhc_pkg::status_e hdr_fault_code(input int pos);
    wavhc_pkg::status_e c;
    if (pos < 4) c = wavhc_pkg::ST_RIFF_TAG;
    else if (pos < 8) c = wavhc_pkg::ST_OK;
    else if (pos < 12) c = wavhc_pkg::ST_WAVE_TAG;
    else if (pos < 16) c = wavhc_pkg::ST_FMT_TAG;
    else if (pos < 36) c = wavhc_pkg::ST_FORMAT;
    else if (pos < 40) c = wavhc_pkg::ST_DATA_TAG;
    else c = wavhc_pkg::ST_OK;
    return c;
  endfunction

  // Advances the parser model by one byte; returns 1 when a result is due.
  function automatic bit parse_byte(input logic [7:0] b, input logic l,
                                    output wavhc_pkg::res_t r);
    int   pos;
    logic fin;
    r = '0;
    fin = 1'b0;
    case (ph)
      wavhc_pkg::PH_HEADER: begin
        pos = int'(hpos);
        if (pos < 40) begin
          if (hdr_fault_code(pos) != wavhc_pkg::ST_OK && b != hdr_good_byte(pos, '0)) begin
            fin = 1'b1;
            r.status = hdr_fault_code(pos);
          end
        end else begin
          size_acc[8*(pos-40) +: 8] = b;
        end
        if (!fin) begin
          if (pos == 43) begin
            data_size = size_acc;
            data_cnt = '0;
            if (size_acc == '0) begin
              fin = 1'b1;
            end else begin
              ph = wavhc_pkg::PH_DATA;
              if (l) begin
                fin = 1'b1;
                r.status = wavhc_pkg::ST_SHORT_DATA;
              end
            end
          end else begin
            hpos = hpos + 1'b1;
            if (l) begin
              fin = 1'b1;
              r.status = wavhc_pkg::ST_SHORT_HDR;
            end
          end
        end
      end
      wavhc_pkg::PH_DATA: begin
        data_cnt = data_cnt + 1;
        if (data_cnt[0]) begin
          low_hold = b;
        end else begin
          r.sample_valid = 1'b1;
          r.sample = {b, low_hold};
        end
        if (data_cnt == data_size) begin
          fin = 1'b1;
        end else if (l) begin
          fin = 1'b1;
          r.status = wavhc_pkg::ST_SHORT_DATA;
        end
      end
      default: ;
    endcase
    r.done_res = fin;
    if (l) begin
      ph = wavhc_pkg::PH_HEADER;
      hpos = '0;
      size_acc = '0;
      data_size = '0;
      data_cnt = '0;
      low_hold = '0;
    end else if (fin) begin
      ph = wavhc_pkg::PH_DRAIN;
    end
    return r.sample_valid || fin;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR %s: got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  // Sends one byte; a pinned status replaces the predicted one on the end result.
  task automatic push_byte(input logic [7:0] b, input logic l, input bit pin,
                           input wavhc_pkg::status_e pin_st);
    wavhc_pkg::res_t r;
    int              gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    s_axis_tlast_i <= l;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sent_items++;
    if (parse_byte(b, l, r)) begin
      if (pin && r.done_res) r.status = pin_st;
      results_due.push_back(r);
    end
  endtask

  task automatic send_file(input bit noise, input int fault_pos, input int hdr_len,
                           input logic [31:0] sz, input int data_len, input bit pat,
                           input bit pin, input wavhc_pkg::status_e pin_st);
    logic [7:0] v;
    int         total;
    int         i;
    total = hdr_len + data_len;
    for (i = 0; i < total; i++) begin
      if (i < hdr_len) begin
        v = noise ? 8'($urandom) : hdr_good_byte(i, sz);
        if (i == fault_pos) v = v ^ 8'($urandom_range(1, 255));
      end else if (pat) begin
        v = ExtremeData[8*((i-hdr_len)%8) +: 8];
      end else begin
        v = 8'($urandom);
      end
      push_byte(v, i == total - 1, pin, pin_st);
    end
  endtask

  // Register writes only once the stream has drained.
  task automatic set_rates(input logic [31:0] sr, input logic [31:0] br);
    s_axis_tvalid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= wavhc_pkg::CFG_SAMPLE_RATE;
    cfg_data_i <= sr;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    want_sr = sr;
    cfg_index_i <= wavhc_pkg::CFG_BYTE_RATE;
    cfg_data_i <= br;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    want_br = br;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_rate(input bit byte_side);
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = byte_side ? RstBr : RstSr;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      m_axis_tready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      ready_hold <= $urandom_range(0, 5);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : result_check
    wavhc_pkg::res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with none pending", 32'(m_axis_tdata_o), '0);
      end else begin
        want = results_due.pop_front();
        if (m_axis_tdata_o[15:0] !== want.sample)
          report_mismatch("sample", 32'(m_axis_tdata_o[15:0]), 32'(want.sample));
        if (m_axis_tdata_o[16] !== want.sample_valid)
          report_mismatch("sample_valid", 32'(m_axis_tdata_o[16]), 32'(want.sample_valid));
        if (m_axis_tdata_o[19:17] !== want.status)
          report_mismatch("status", 32'(m_axis_tdata_o[19:17]), 32'(want.status));
        if (m_axis_tdata_o[23:20] !== 4'h0)
          report_mismatch("tdata pad", 32'(m_axis_tdata_o[23:20]), '0);
        if (m_axis_tlast_o !== want.done_res)
          report_mismatch("done", 32'(m_axis_tlast_o), 32'(want.done_res));
      end
    end
  end

  initial begin : stimulus
    int          kind;
    int          sz;
    int          dl;
    int          fp;
    int          hl;
    logic [31:0] big;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_on <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[k]) begin
      if (DirRows[k].sr != want_sr || DirRows[k].br != want_br)
        set_rates(DirRows[k].sr, DirRows[k].br);
      send_file(1'b0, DirRows[k].fault_pos, DirRows[k].hdr_len, DirRows[k].decl_size,
                DirRows[k].data_len, DirRows[k].pat, 1'b1, DirRows[k].st);
    end

    while (sent_items < 800) begin
      // quiet stretches now and then, and none at all near the end
      idle_on <= (sent_items < 680) && ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 4) == 0) set_rates(pick_rate(1'b0), pick_rate(1'b1));
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        sz = $urandom_range(0, 19);
        if (sz == 0) begin
          big = $urandom;
          send_file(1'b0, NoFault, 44, big, $urandom_range(0, 20), 1'b0, 1'b0,
                    wavhc_pkg::ST_OK);
        end else begin
          sz = (sz < 3) ? $urandom_range(41, 300) : $urandom_range(0, 40);
          case ($urandom_range(0, 4))
            0: dl = sz + $urandom_range(1, 6);
            1: dl = (sz > 0) ? $urandom_range(0, sz - 1) : 0;
            default: dl = sz;
          endcase
          send_file(1'b0, NoFault, 44, sz, dl, 1'b0, 1'b0, wavhc_pkg::ST_OK);
        end
      end else if (kind < 78) begin
        fp = $urandom_range(0, 35);
        if (fp >= 4) fp = fp + 4;
        hl = ($urandom_range(0, 2) == 0) ? fp + 1 + $urandom_range(0, 5) : 44;
        if (hl > 44) hl = 44;
        dl = (hl == 44) ? $urandom_range(0, 6) : 0;
        send_file(1'b0, fp, hl, $urandom_range(0, 40), dl, 1'b0, 1'b0, wavhc_pkg::ST_OK);
      end else if (kind < 90) begin
        send_file(1'b0, NoFault, $urandom_range(1, 43), $urandom_range(0, 40), 0, 1'b0,
                  1'b0, wavhc_pkg::ST_OK);
      end else begin
        send_file(1'b1, NoFault, $urandom_range(1, 24), '0, 0, 1'b0, 1'b0,
                  wavhc_pkg::ST_OK);
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/wavhc_pkg.sv
hdl/wavhc_cfg.sv
hdl/wavhc_parse.sv
hdl/wavhc_outq.sv
hdl/wav_header_check_sample_unpack_unit.sv
tb/sv/tb.sv
